### sv/hsv_to_rgb_converter_core_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTH
`define HSV_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("hsv_to_rgb_converter_core: same-cycle check failed");
`define HSV_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("hsv_to_rgb_converter_core: next-cycle check failed");
`else
`define HSV_ASSERT_NOW(lbl, ant, con)
`define HSV_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

### sv/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, fixed-point constants and shared types of the converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_FRAC_BITS = 4;
    localparam int SV_FRAC_BITS  = 8;

    localparam int HUE_W   = 13;
    localparam int SV_W    = 9;
    localparam int CHAN_W  = 8;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 24;

    localparam int DEG60   = 60 << HUE_FRAC_BITS;
    localparam int SV_ONE  = 1 << SV_FRAC_BITS;
    localparam int HUE_MAX = 360 << HUE_FRAC_BITS;

    // Distance from the secondary hue of the sector, 0 to 60 degrees in hue units.
    localparam int D_W = 10;
    // Chroma product s*v.
    localparam int P_W = 2 * SV_W;
    // Numerators over the common denominator SV_ONE^2 * DEG60.
    localparam int A_W = P_W + D_W;
    localparam int A_SCALE = SV_ONE * DEG60;

    // The denominator is 2^22 * 15; the odd part is removed by a reciprocal.
    localparam int DEN_SHIFT   = 22;
    localparam int SCALED_W    = A_W + 8;
    localparam int Y_W         = SCALED_W - DEN_SHIFT;
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP       = 8739;
    localparam int RECIP_W     = 14;
    localparam int QP_W        = Y_W + RECIP_W;
    localparam int Q_W         = QP_W - RECIP_SHIFT;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef enum logic [1:0] {
        ROLE_FULL = 2'd0,
        ROLE_MID  = 2'd1,
        ROLE_ZERO = 2'd2
    } role_t;

    typedef struct packed {
        logic                err;
        sector_t             sector;
        logic [D_W-1:0]      d;
        logic [P_W-1:0]      p;
        logic [SV_W-1:0]     v;
    } front_t;

    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctl_t;

endpackage

### sv/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Streaming conversion of one HSV pixel per clock to 8-bit RGB, unless stalled.
// ----------------------------------------------------------------------------
// A pixel enters on the s_axis channel as hue, saturation and brightness and
// leaves on the m_axis channel as red, green and blue, with range_error in
// tuser. Each input transaction gives exactly one output transaction.
// The pipeline has four register stages: the range check and sector, the
// channel products, the scaling by 255 and the division by the odd part of
// the denominator. Throughput is one pixel per cycle while m_axis_tready is
// high; the longest path is one product stage.
// Out-of-range inputs give black with range_error set.
// Reset clears the stage valid bits only; the data registers are not reset.
// When the receiver deasserts m_axis_tready, full stages hold their data and
// empty stages keep filling, so s_axis_tready drops only once every stage is
// occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // hue[12:0], saturation[21:13], brightness[30:22], zero[31]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [OUT_W-1:0] m_axis_tdata,
    // range_error[0]
    output logic             m_axis_tuser
);

    logic        vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic        vld1_next, vld2_next, vld3_next, vld4_next;
    logic        err2_reg, err3_reg, err4_reg;
    logic        rdy1, rdy2, rdy3, rdy4;
    pipe_ctl_t   ctl;
    front_t      st1;
    logic [CHAN_W-1:0] red, green, blue;

    always_comb
    begin
        rdy4 = m_axis_tready || !vld4_reg;
        rdy3 = rdy4 || !vld3_reg;
        rdy2 = rdy3 || !vld2_reg;
        rdy1 = rdy2 || !vld1_reg;

        ctl.ld2 = rdy2;
        ctl.ld3 = rdy3;
        ctl.ld4 = rdy4;

        vld1_next = rdy1 ? s_axis_tvalid : vld1_reg;
        vld2_next = rdy2 ? vld1_reg : vld2_reg;
        vld3_next = rdy3 ? vld2_reg : vld3_reg;
        vld4_next = rdy4 ? vld3_reg : vld4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            vld3_reg <= vld3_next;
            vld4_reg <= vld4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            err2_reg <= st1.err;
        end
        if (rdy3)
        begin
            err3_reg <= err2_reg;
        end
        if (rdy4)
        begin
            err4_reg <= err3_reg;
        end
    end

    hsvrgb_front u_front (
        .clk        (clk),
        .ld         (rdy1),
        .hue        (s_axis_tdata[HUE_W-1:0]),
        .saturation (s_axis_tdata[HUE_W+SV_W-1:HUE_W]),
        .brightness (s_axis_tdata[HUE_W+2*SV_W-1:HUE_W+SV_W]),
        .st_reg     (st1)
    );

    hsvrgb_chan u_red (
        .clk       (clk),
        .ctl       (ctl),
        .chan      (CH_RED),
        .st        (st1),
        .blank     (err3_reg),
        .level_reg (red)
    );

    hsvrgb_chan u_green (
        .clk       (clk),
        .ctl       (ctl),
        .chan      (CH_GREEN),
        .st        (st1),
        .blank     (err3_reg),
        .level_reg (green)
    );

    hsvrgb_chan u_blue (
        .clk       (clk),
        .ctl       (ctl),
        .chan      (CH_BLUE),
        .st        (st1),
        .blank     (err3_reg),
        .level_reg (blue)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = vld4_reg;
    assign m_axis_tdata  = {blue, green, red};
    assign m_axis_tuser  = err4_reg;

    `HSV_ASSERT_NOW(a_error_black, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `HSV_ASSERT_NEXT(a_stall_hold, vld3_reg && !rdy3, vld3_reg && $stable(err3_reg))
    `HSV_ASSERT_NOW(a_full_backpressure, !rdy3 && vld2_reg && vld1_reg, !s_axis_tready)

endmodule

### sv/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter front stage
// Range check, hue sector, distance from the secondary and the chroma product.
// ----------------------------------------------------------------------------
module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  logic              clk,
    input  logic              ld,
    input  logic [HUE_W-1:0]  hue,
    input  logic [SV_W-1:0]   saturation,
    input  logic [SV_W-1:0]   brightness,
    output front_t            st_reg
);

    localparam logic [HUE_W-1:0] H60  = HUE_W'(DEG60);
    localparam logic [HUE_W-1:0] H120 = HUE_W'(2 * DEG60);
    localparam logic [HUE_W-1:0] H180 = HUE_W'(3 * DEG60);
    localparam logic [HUE_W-1:0] H240 = HUE_W'(4 * DEG60);
    localparam logic [HUE_W-1:0] H300 = HUE_W'(5 * DEG60);
    localparam logic [HUE_W-1:0] HMAX = HUE_W'(HUE_MAX);
    localparam logic [SV_W-1:0]  ONE  = SV_W'(SV_ONE);

    sector_t          sector;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] off;
    logic             odd;
    front_t           st_next;

    always_comb
    begin
        if (hue < H60)
        begin
            sector = SEC_RED_YEL;
        end
        else if (hue < H120)
        begin
            sector = SEC_YEL_GRN;
        end
        else if (hue < H180)
        begin
            sector = SEC_GRN_CYN;
        end
        else if (hue < H240)
        begin
            sector = SEC_CYN_BLU;
        end
        else if (hue < H300)
        begin
            sector = SEC_BLU_MAG;
        end
        else
        begin
            sector = SEC_MAG_RED;
        end

        case (sector)
            SEC_RED_YEL: base = '0;
            SEC_YEL_GRN: base = H60;
            SEC_GRN_CYN: base = H120;
            SEC_CYN_BLU: base = H180;
            SEC_BLU_MAG: base = H240;
            default:     base = H300;
        endcase

        off = hue - base;
        odd = (sector == SEC_YEL_GRN) || (sector == SEC_CYN_BLU) ||
              (sector == SEC_MAG_RED);

        st_next.err    = (hue > HMAX) || (saturation > ONE) || (brightness > ONE);
        st_next.sector = sector;
        st_next.d      = odd ? off[D_W-1:0] : (D_W'(DEG60) - off[D_W-1:0]);
        st_next.p      = P_W'(saturation) * P_W'(brightness);
        st_next.v      = brightness;
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            st_reg <= st_next;
        end
    end

endmodule

### sv/hsvrgb_chan.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter channel
// Three-stage datapath that scales one color channel to eight bits.
// ----------------------------------------------------------------------------
module hsvrgb_chan
    import hsvrgb_pkg::*;
(
    input  logic              clk,
    input  pipe_ctl_t         ctl,
    input  chan_t             chan,
    input  front_t            st,
    input  logic              blank,
    output logic [CHAN_W-1:0] level_reg
);

    role_t                 role;
    logic [D_W-1:0]        k;
    logic [A_W-1:0]        prod_reg;
    logic [A_W-1:0]        a_reg;
    logic [A_W-1:0]        diff;
    logic [SCALED_W-1:0]   scaled;
    logic [Y_W-1:0]        y_reg;
    logic [QP_W-1:0]       qprod;
    logic [Q_W-1:0]        q;
    logic [CHAN_W-1:0]     level_next;

    // The channel numerator is SV_ONE*DEG60*v - s*v*k, with k zero for the
    // chroma channel, the secondary distance for the mixed one and 60 degrees
    // for the empty one.
    always_comb
    begin
        case (st.sector)
            SEC_RED_YEL:
            begin
                role = (chan == CH_RED) ? ROLE_FULL :
                       (chan == CH_GREEN) ? ROLE_MID : ROLE_ZERO;
            end
            SEC_YEL_GRN:
            begin
                role = (chan == CH_RED) ? ROLE_MID :
                       (chan == CH_GREEN) ? ROLE_FULL : ROLE_ZERO;
            end
            SEC_GRN_CYN:
            begin
                role = (chan == CH_RED) ? ROLE_ZERO :
                       (chan == CH_GREEN) ? ROLE_FULL : ROLE_MID;
            end
            SEC_CYN_BLU:
            begin
                role = (chan == CH_RED) ? ROLE_ZERO :
                       (chan == CH_GREEN) ? ROLE_MID : ROLE_FULL;
            end
            SEC_BLU_MAG:
            begin
                role = (chan == CH_RED) ? ROLE_MID :
                       (chan == CH_GREEN) ? ROLE_ZERO : ROLE_FULL;
            end
            default:
            begin
                role = (chan == CH_RED) ? ROLE_FULL :
                       (chan == CH_GREEN) ? ROLE_ZERO : ROLE_MID;
            end
        endcase

        case (role)
            ROLE_FULL: k = '0;
            ROLE_MID:  k = st.d;
            default:   k = D_W'(DEG60);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            prod_reg <= A_W'(st.p) * A_W'(k);
            a_reg    <= A_W'(st.v) * A_W'(A_SCALE);
        end
    end

    always_comb
    begin
        diff   = a_reg - prod_reg;
        scaled = (SCALED_W'(diff) << 8) - SCALED_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            y_reg <= scaled[SCALED_W-1:DEN_SHIFT];
        end
    end

    always_comb
    begin
        qprod = QP_W'(y_reg) * QP_W'(RECIP);
        q     = qprod[QP_W-1:RECIP_SHIFT];
        if (blank)
        begin
            level_next = '0;
        end
        else if (q > Q_W'(255))
        begin
            level_next = '1;
        end
        else
        begin
            level_next = q[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            level_reg <= level_next;
        end
    end

endmodule
